/* rtl/core/prc_pkg.sv */
// Shared types, constants and helpers of the polar/rectangular converter.
package prc_pkg;

   // Datapath widths of the CORDIC cell chain
   localparam int XW         = 60;
   localparam int ZW         = 34;
   localparam int ANG_FRAC   = 24;
   localparam int VEC_GUARD  = 24;
   localparam int ROOT_STEPS = 32;
   localparam int TABLE_LEN  = 32;

   // Inverse CORDIC gain in Q30: base plus a tail that shrinks with stage count
   localparam longint INVK_BASE = 652032874;
   localparam longint INVK_TAIL = 434688583;

   // round(atan(2^-i) in degrees * 2^24)
   localparam logic [31:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
      32'd234684,    32'd117342,    32'd58671,     32'd29335,
      32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115,
      32'd57,        32'd29,        32'd14,        32'd7,
      32'd4,         32'd2,         32'd1,         32'd0
   };

   // Word handed from cell to cell
   typedef struct packed {
      logic                 rot;   // rotation pass (polar input)
      logic                 flip;  // negate x,y after rotation
      logic                 zero;  // rectangular origin
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [63:0]          rem;   // square root remainder
      logic [63:0]          root;  // square root partial result
      logic signed [31:0]   a;     // first value as received
      logic signed [31:0]   b;     // second value as received
   } prc_cell_type;

   // Clamp a wide signed value to the 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [31:0] res;
      if (v > 72'sh0_0000_0000_7FFF_FFFF) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -72'sh0_0000_0000_8000_0000) begin
         res = -32'sh8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

/* rtl/core/prc_channels_if.sv */
// Request and response channel interfaces of the polar/rectangular converter.
interface prc_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [31:0] first_value;
   logic signed [31:0] second_value;

   modport source (output valid, func, first_value, second_value, input ready);
   modport sink   (input valid, func, first_value, second_value, output ready);
endinterface

interface prc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_out;
   logic signed [31:0] y_out;
   logic signed [31:0] magnitude;
   logic signed [31:0] angle_deg;

   modport source (output valid, x_out, y_out, magnitude, angle_deg, input ready);
   modport sink   (input valid, x_out, y_out, magnitude, angle_deg, output ready);
endinterface

/* rtl/core/prc_front.sv */
// Input stages: magnitudes, squares, angle reduction and CORDIC start values.
module prc_front import prc_pkg::*; #(
   parameter int CORDIC_STAGES = 16,
   parameter int FRAC_BITS     = 16
) (
   input  logic         clock,
   input  logic         reset,
   prc_req_if.sink      req_if,
   output logic         out_valid,
   input  logic         out_ready,
   output prc_cell_type out_data
);

   localparam int              GS        = 2 * CORDIC_STAGES;
   localparam longint          INVK      = (GS < 40) ?
      INVK_BASE + ((INVK_TAIL + (64'sd1 <<< (GS - 1))) >>> GS) : INVK_BASE;
   localparam longint          PERIOD_L  = 64'sd360 <<< FRAC_BITS;
   localparam longint          RECIP_L   = ((64'sd1 <<< 40) + PERIOD_L / 2) / PERIOD_L;
   localparam logic signed [25:0] RECIP  = 26'(RECIP_L);
   localparam logic signed [39:0] PERIOD = 40'(PERIOD_L);
   localparam logic signed [39:0] HALF   = 40'(64'sd180 <<< FRAC_BITS);
   localparam logic signed [39:0] QUART  = 40'(64'sd90 <<< FRAC_BITS);
   localparam int              ZSH       = ANG_FRAC - FRAC_BITS;
   localparam logic signed [ZW-1:0] QUARTER_Z = ZW'(64'sd90 <<< ANG_FRAC);

   // Stage 1 registers
   logic               v1_ff, rdy1;
   logic               f1_ff;
   logic signed [31:0] a1_ff, b1_ff;
   logic [31:0]        ax1_ff, ay1_ff;
   logic signed [32:0] vx1_ff, vy1_ff;
   logic signed [ZW-1:0] vz1_ff;
   logic signed [57:0] prod1_ff;
   logic [31:0]        ax1_in, ay1_in;
   logic signed [32:0] vx1_in, vy1_in, a33, b33;
   logic signed [ZW-1:0] vz1_in;
   logic signed [57:0] prod1_in;

   // Stage 2 registers
   logic               v2_ff, rdy2;
   logic               f2_ff;
   logic signed [31:0] a2_ff, b2_ff;
   logic signed [32:0] vx2_ff, vy2_ff;
   logic signed [ZW-1:0] vz2_ff;
   logic [63:0]        sq2_ff, sq2_in;
   logic signed [39:0] r2_ff, r2_in;
   logic signed [17:0] quo;

   // Stage 3 register
   logic               v3_ff, rdy3;
   prc_cell_type       d3_ff, d3_in;
   logic signed [39:0] red;
   logic               flip;

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_if.ready = rdy1;
   assign out_valid = v3_ff;
   assign out_data  = d3_ff;

   // Absolute values, pre-rotation into the right half plane, reciprocal product
   always_comb begin
      a33 = {req_if.first_value[31], req_if.first_value};
      b33 = {req_if.second_value[31], req_if.second_value};
      ax1_in = 32'(a33[32] ? -a33 : a33);
      ay1_in = 32'(b33[32] ? -b33 : b33);
      if (a33[32]) begin
         if (!b33[32]) begin
            vx1_in = b33;
            vy1_in = -a33;
            vz1_in = QUARTER_Z;
         end else begin
            vx1_in = -b33;
            vy1_in = a33;
            vz1_in = -QUARTER_Z;
         end
      end else begin
         vx1_in = a33;
         vy1_in = b33;
         vz1_in = '0;
      end
      prod1_in = req_if.second_value * RECIP;
   end

   // Sum of squares and first remainder of the angle modulo one turn
   always_comb begin
      quo    = 18'(prod1_ff >>> 40);
      sq2_in = ax1_ff * ax1_ff + ay1_ff * ay1_ff;
      r2_in  = b1_ff - quo * PERIOD;
   end

   // Fold the angle into -90..90 and set up the cell chain
   always_comb begin
      red  = r2_ff;
      flip = 1'b0;
      if (red < 0) begin
         red = red + PERIOD;
      end else if (red >= PERIOD) begin
         red = red - PERIOD;
      end
      if (red >= HALF) begin
         red = red - PERIOD;
      end
      if (red > QUART) begin
         red  = red - HALF;
         flip = 1'b1;
      end else if (red < -QUART) begin
         red  = red + HALF;
         flip = 1'b1;
      end
      d3_in.rot  = f2_ff;
      d3_in.zero = (a2_ff == 32'sd0) && (b2_ff == 32'sd0);
      d3_in.rem  = sq2_ff;
      d3_in.root = '0;
      d3_in.a    = a2_ff;
      d3_in.b    = b2_ff;
      if (f2_ff) begin
         d3_in.flip = flip;
         d3_in.x    = XW'(INVK);
         d3_in.y    = '0;
         d3_in.z    = ZW'(red <<< ZSH);
      end else begin
         d3_in.flip = 1'b0;
         d3_in.x    = XW'(vx2_ff) <<< VEC_GUARD;
         d3_in.y    = XW'(vy2_ff) <<< VEC_GUARD;
         d3_in.z    = vz2_ff;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_if.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Load payload words
   always_ff @(posedge clock) begin
      if (rdy1 && req_if.valid) begin
         f1_ff    <= req_if.func;
         a1_ff    <= req_if.first_value;
         b1_ff    <= req_if.second_value;
         ax1_ff   <= ax1_in;
         ay1_ff   <= ay1_in;
         vx1_ff   <= vx1_in;
         vy1_ff   <= vy1_in;
         vz1_ff   <= vz1_in;
         prod1_ff <= prod1_in;
      end
      if (rdy2 && v1_ff) begin
         f2_ff  <= f1_ff;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         vx2_ff <= vx1_ff;
         vy2_ff <= vy1_ff;
         vz2_ff <= vz1_ff;
         sq2_ff <= sq2_in;
         r2_ff  <= r2_in;
      end
      if (rdy3 && v2_ff) begin
         d3_ff <= d3_in;
      end
   end

endmodule

/* rtl/core/prc_cell.sv */
// One cell of the chain: a CORDIC micro-rotation (when IDX < CORDIC_STAGES) and one square root digit.
module prc_cell import prc_pkg::*; #(
   parameter int IDX           = 0,
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  prc_cell_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output prc_cell_type out_data
);

   localparam bit          ROTATE_ON = IDX < CORDIC_STAGES;
   localparam logic [63:0] ROOT_BIT  = 64'd1 << (62 - 2 * IDX);
   localparam logic signed [ZW-1:0] ATAN_STEP = ZW'({2'b00, ATAN_DEG_Q24[IDX]});

   logic         valid_ff;
   prc_cell_type data_ff, data_in;
   logic signed [XW-1:0] cx, cy, dx, dy;
   logic signed [ZW-1:0] cz;
   logic [63:0]  trial;
   logic         up;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Step the rotation and the root digit
   always_comb begin
      data_in = in_data;
      cx = in_data.x;
      cy = in_data.y;
      cz = in_data.z;
      dx = cy >>> IDX;
      dy = cx >>> IDX;
      up = in_data.rot ? !cz[ZW-1] : cy[XW-1];
      if (ROTATE_ON) begin
         if (up) begin
            data_in.x = cx - dx;
            data_in.y = cy + dy;
            data_in.z = cz - ATAN_STEP;
         end else begin
            data_in.x = cx + dx;
            data_in.y = cy - dy;
            data_in.z = cz + ATAN_STEP;
         end
      end
      trial = in_data.root + ROOT_BIT;
      if (in_data.rem >= trial) begin
         data_in.rem  = in_data.rem - trial;
         data_in.root = (in_data.root >> 1) + ROOT_BIT;
      end else begin
         data_in.root = in_data.root >> 1;
      end
   end

   // Hold or advance the word
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/core/prc_back.sv */
// Output stages: scaling by magnitude, rounding, saturation and the result register.
module prc_back import prc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  prc_cell_type in_data,
   prc_rsp_if.source    rsp_if
);

   localparam int SH = ANG_FRAC - FRAC_BITS;
   localparam logic signed [35:0] HALF_LSB = (36'sd1 <<< SH) >>> 1;
   localparam logic signed [ZW-1:0] LIM = ZW'(64'sd180 <<< ANG_FRAC);
   localparam logic signed [65:0] ROUND30 = 66'sd1 <<< 29;
   localparam logic [63:0] MAG_MAX = 64'h0000_0000_7FFF_FFFF;

   // Stage 1
   logic               v1_ff, rdy1, rdy2;
   logic               rot1_ff, zero1_ff;
   logic signed [31:0] a1_ff, b1_ff;
   logic signed [64:0] px1_ff, py1_ff, px1_in, py1_in;
   logic signed [ZW-1:0] z1_ff, z1_in;
   logic [31:0]        mag1_ff, mag1_in;
   logic signed [32:0] rx, ry;
   logic [63:0]        rootc;

   // Output register
   logic               o_valid_ff;
   logic signed [31:0] ox_ff, oy_ff, om_ff, oa_ff;
   logic signed [31:0] ox_in, oy_in, om_in, oa_in;
   logic signed [65:0] xr, yr;
   logic signed [35:0] ar;

   assign rdy2 = !o_valid_ff || rsp_if.ready;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign rsp_if.valid     = o_valid_ff;
   assign rsp_if.x_out     = ox_ff;
   assign rsp_if.y_out     = oy_ff;
   assign rsp_if.magnitude = om_ff;
   assign rsp_if.angle_deg = oa_ff;

   // Scale the unit vector, clamp the angle, finish the root
   always_comb begin
      rx = in_data.x[32:0];
      ry = in_data.y[32:0];
      if (in_data.flip) begin
         rx = -rx;
         ry = -ry;
      end
      px1_in = in_data.a * rx;
      py1_in = in_data.a * ry;
      z1_in = in_data.z;
      if (z1_in > LIM) z1_in = LIM;
      if (z1_in < -LIM) z1_in = -LIM;
      rootc = in_data.root + 64'(in_data.rem > in_data.root);
      mag1_in = (rootc > MAG_MAX) ? MAG_MAX[31:0] : rootc[31:0];
   end

   // Round and saturate, then pick the result word
   always_comb begin
      xr = (66'(px1_ff) + ROUND30) >>> 30;
      yr = (66'(py1_ff) + ROUND30) >>> 30;
      ar = zero1_ff ? 36'sd0 : ((36'(z1_ff) + HALF_LSB) >>> SH);
      if (rot1_ff) begin
         ox_in = sat32(72'(xr));
         oy_in = sat32(72'(yr));
         om_in = a1_ff;
         oa_in = b1_ff;
      end else begin
         ox_in = a1_ff;
         oy_in = b1_ff;
         om_in = signed'(mag1_ff);
         oa_in = sat32(72'(ar));
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) o_valid_ff <= v1_ff;
      end
   end

   // Load payload words
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         rot1_ff  <= in_data.rot;
         zero1_ff <= in_data.zero;
         a1_ff    <= in_data.a;
         b1_ff    <= in_data.b;
         px1_ff   <= px1_in;
         py1_ff   <= py1_in;
         z1_ff    <= z1_in;
         mag1_ff  <= mag1_in;
      end
      if (rdy2 && v1_ff) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         om_ff <= om_in;
         oa_ff <= oa_in;
      end
   end

endmodule

/* rtl/core/polar_rect_converter_top.sv */
// Top level of the polar/rectangular converter.
// Converts one coordinate pair per clock: func 0 takes x,y and returns them
// with the rounded length and the four-quadrant angle in degrees; func 1
// takes length,degrees and returns them with x and y. All values are signed
// fixed point with FRAC_BITS fraction bits, saturated to 32 bits. Each word
// passes three input stages, a chain of 32 cells (each one CORDIC
// micro-rotation, the first CORDIC_STAGES of them active, and one square
// root digit) and two output stages; a new word is taken every cycle, and
// stalls on the response side fill empty stages before the request side is
// held off.
module polar_rect_converter_top import prc_pkg::*; #(
   parameter int CORDIC_STAGES = 16,
   parameter int FRAC_BITS     = 16
) (
   input  logic     clock,
   input  logic     reset,
   prc_req_if.sink  req_if,
   prc_rsp_if.source rsp_if
);

   logic         link_valid [ROOT_STEPS+1];
   logic         link_ready [ROOT_STEPS+1];
   prc_cell_type link_data  [ROOT_STEPS+1];

   prc_front #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .FRAC_BITS     (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // Chain of cells
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_cell
      prc_cell #(
         .IDX           (k),
         .CORDIC_STAGES (CORDIC_STAGES)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   prc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (link_valid[ROOT_STEPS]),
      .in_ready (link_ready[ROOT_STEPS]),
      .in_data  (link_data[ROOT_STEPS]),
      .rsp_if   (rsp_if)
   );

endmodule
